// File: rtl/core/olad_pkg.sv
// Shared types and constants for the ordered list core.
// No dependencies; imported by olad_cmp, olad_ctrl and the top level.
`timescale 1ns / 1ps

package olad_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_DELETE   = 2'd1,
        MODE_TRAVERSE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DELETED   = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_ITEM      = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_LIST   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    // flags from the shared compare unit
    typedef struct packed {
        logic eq;         // read data equals key
        logic rd_more;    // read index still below entry count
        logic pidx_last;  // data in hand belongs to the tail entry
    } t_cmp;

endpackage

// File: rtl/core/olad_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module olad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/olad_cmp.sv
// Shared compare unit: key match and index bound checks for the sequencer.
// Depends on olad_pkg.
`timescale 1ns / 1ps

module olad_cmp #(
    parameter int CNT_W = 5
) (
    input  logic [olad_pkg::DATA_W-1:0] i_rdata,
    input  logic [olad_pkg::DATA_W-1:0] i_key,
    input  logic [CNT_W-1:0]            i_idx,
    input  logic [CNT_W-1:0]            i_pidx,
    input  logic [CNT_W-1:0]            i_count,
    output olad_pkg::t_cmp              o_res
);
    import olad_pkg::*;

    always_comb begin
        o_res.eq        = (i_rdata == i_key);
        o_res.rd_more   = (i_idx < i_count);
        o_res.pidx_last = ((i_pidx + CNT_W'(1)) == i_count);
    end

endmodule

// File: rtl/core/olad_ctrl.sv
// Sequencer for insert, delete and traverse, with the output register.
// Depends on olad_pkg and olad_cmp; drives an external olad_ram.
`timescale 1ns / 1ps

module olad_ctrl #(
    parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [olad_pkg::DATA_W-1:0]     i_s_tdata,
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [olad_pkg::DATA_W-1:0]     o_m_tdata,
    output logic [2:0]                      o_m_tuser,
    output logic                            o_m_tlast,
    output logic                            o_we,
    output logic [$clog2(CAPACITY)-1:0]     o_waddr,
    output logic [olad_pkg::DATA_W-1:0]     o_wdata,
    output logic                            o_re,
    output logic [$clog2(CAPACITY)-1:0]     o_raddr,
    input  logic [olad_pkg::DATA_W-1:0]     i_rdata
);
    import olad_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_key, n_key;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pidx, n_pidx;
    logic              r_pv, n_pv;
    t_status           r_res, n_res;
    logic              r_m_valid, n_m_valid;
    t_status           r_m_status, n_m_status;
    logic [DATA_W-1:0] r_m_data, n_m_data;
    logic              r_m_last, n_m_last;

    t_cmp              c;
    logic              out_free;
    logic              emit;
    logic [CW-1:0]     waddr_full;

    olad_cmp #(
        .CNT_W (CW)
    ) u_cmp (
        .i_rdata (i_rdata),
        .i_key   (r_key),
        .i_idx   (r_idx),
        .i_pidx  (r_pidx),
        .i_count (r_count),
        .o_res   (c)
    );

    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pv       = r_pv;
        n_res      = r_res;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_status = r_m_status;
        n_m_data   = r_m_data;
        n_m_last   = r_m_last;
        o_we       = 1'b0;
        waddr_full = r_count;
        o_wdata    = i_s_tdata;
        o_re       = 1'b0;
        emit       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_key = i_s_tdata;
                    n_idx = '0;
                    n_pv  = 1'b0;
                    case (t_mode'(i_s_tuser))
                        MODE_INSERT: begin
                            n_state = S_EMIT;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_res = STAT_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + CW'(1);
                                n_res   = STAT_INSERTED;
                            end
                        end
                        MODE_DELETE: begin
                            if (r_count == '0) begin
                                n_res   = STAT_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        MODE_TRAVERSE: begin
                            if (r_count == '0) begin
                                n_res   = STAT_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_pv && c.eq) begin
                    n_pv = 1'b0;
                    if (c.pidx_last) begin
                        n_count = r_count - CW'(1);
                        n_res   = STAT_DELETED;
                        n_state = S_EMIT;
                    end else begin
                        n_idx   = r_pidx + CW'(1);
                        n_state = S_SHIFT;
                    end
                end else if (r_pv && c.pidx_last) begin
                    n_pv    = 1'b0;
                    n_res   = STAT_NOT_FOUND;
                    n_state = S_EMIT;
                end else if (c.rd_more) begin
                    o_re   = 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pv = 1'b0;
                end
            end
            S_SHIFT: begin
                // entry pidx moves down to pidx-1
                if (r_pv) begin
                    o_we       = 1'b1;
                    waddr_full = r_pidx - CW'(1);
                    o_wdata    = i_rdata;
                end
                if (c.rd_more) begin
                    o_re   = 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pv    = 1'b0;
                    n_count = r_count - CW'(1);
                    n_res   = STAT_DELETED;
                    n_state = S_EMIT;
                end
            end
            S_LIST: begin
                emit = r_pv && out_free;
                if (emit) begin
                    n_m_valid  = 1'b1;
                    n_m_status = STAT_ITEM;
                    n_m_data   = i_rdata;
                    n_m_last   = c.pidx_last;
                end
                if (emit && c.pidx_last) begin
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end else if ((!r_pv || out_free) && c.rd_more) begin
                    o_re   = 1'b1;
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end else if (emit) begin
                    n_pv = 1'b0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res;
                    n_m_data   = r_key;
                    n_m_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pv      <= n_pv;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_res      <= n_res;
        r_m_status <= n_m_status;
        r_m_data   <= n_m_data;
        r_m_last   <= n_m_last;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_waddr    = waddr_full[AW-1:0];
    assign o_raddr    = r_idx[AW-1:0];
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_status;
    assign o_m_tlast  = r_m_last;

endmodule

// File: rtl/core/ordered_list_append_delete_core.sv
// Top level of the ordered list core: sequencer plus entry RAM.
// Depends on olad_pkg, olad_ctrl, olad_cmp and olad_ram.
//
//  channel  dir  handshake              tdata        tuser       tlast
//  s        in   i_s_tvalid/o_s_tready  data_value   mode        -
//  m        out  o_m_tvalid/i_m_tready  item_value   status      last
//
// Insert appends the key at the tail unless the list is full; delete searches the
// list, pipelined one entry a cycle through the RAM read port, and on a match that
// is not the tail moves each later entry up one place; traverse sends one entry a
// cycle while the output is not stalled; on an empty list both report empty.
// o_s_tready is high only while the sequencer is idle; the result register lets
// the next item in while a result still waits. Output stalls hold the sequencer.
// Reset is synchronous and empties the list; RAM contents are not cleared.
`timescale 1ns / 1ps

module ordered_list_append_delete_core #(
    parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [olad_pkg::DATA_W-1:0] i_s_tdata,   // [31:0] data_value
    input  logic [1:0]                  i_s_tuser,   // [1:0] mode
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [olad_pkg::DATA_W-1:0] o_m_tdata,   // [31:0] item_value
    output logic [2:0]                  o_m_tuser,   // [2:0] status
    output logic                        o_m_tlast
);
    import olad_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;

    olad_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    olad_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
